[sv/ecct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Equal circle common tangents: shared types and arithmetic helpers
// Item and result layouts, the record passed from the math pipeline to the
// result sequencer, and the fixed-point rounding and saturation helpers.
// ----------------------------------------------------------------------------
package ecct_pkg;

  // Unit vectors and the internal cosine and sine are Q30
  localparam int UnitShift = 30;
  localparam logic [63:0] RoundHalf = 64'd1 << (UnitShift - 1);
  localparam logic [30:0] UnitOne = 31'd1 << UnitShift;
  localparam logic [61:0] UnitOneSq = 62'd1 << (2 * UnitShift);

  // Depth of the queue between the math pipeline and the sequencer
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  // Result steps of one run
  localparam logic [1:0] StepExt0 = 2'd0;
  localparam logic [1:0] StepExt1 = 2'd1;
  localparam logic [1:0] StepInt0 = 2'd2;
  localparam logic [1:0] StepInt1 = 2'd3;

  typedef struct packed {
    logic signed [31:0] first_center_x;
    logic signed [31:0] first_center_y;
    logic signed [31:0] second_center_x;
    logic signed [31:0] second_center_y;
    logic [30:0]        circle_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_one_x;
    logic signed [31:0] point_one_y;
    logic signed [31:0] point_two_x;
    logic signed [31:0] point_two_y;
    logic               tangent_kind;
    logic               tangent_side;
    logic               last_of_run;
  } out_item_t;

  // Per-item sideband carried down the math pipeline
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [30:0]        r;
    logic               internal;
    logic               keep;
  } item_t;

  // Finished offsets of one item, ready for emission
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic               internal;
    logic signed [33:0] ext_a;
    logic signed [33:0] ext_b;
    logic signed [33:0] oc0;
    logic signed [33:0] os0;
    logic signed [33:0] oc1;
    logic signed [33:0] os1;
  } rec_t;

  // Divide by 2^30, rounding halves away from zero
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q = (mag + RoundHalf) >> UnitShift;
    return v[63] ? -$signed(q[33:0]) : $signed(q[33:0]);
  endfunction

  // Clamp to the signed 32-bit coordinate range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > $signed(36'h07FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (v < $signed(36'hF80000000)) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[sv/ecct_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module ecct_isqrt #(
  parameter int W  = 64,
  parameter int SW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  wire logic [W-1:0]   rad_i,
  input  wire logic [SW-1:0]  side_i,
  output logic                vld_o,
  output logic [W/2-1:0]      root_o,
  output logic [SW-1:0]       side_o
);

  localparam int R  = W / 2;
  localparam int RW = R + 2;

  logic [RW-1:0] rem_r  [R];
  logic [R-1:0]  root_r [R];
  logic [W-1:0]  rad_r  [R];
  logic [SW-1:0] side_r [R];
  logic [R-1:0]  vld_r;

  for (genvar g = 0; g < R; g++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [R-1:0]  root_in;
    logic [W-1:0]  rad_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [RW+1:0] tmp;
    logic [RW+1:0] trial;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [R-1:0]  root_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign side_in = side_r[g-1];
      assign vld_in  = vld_r[g-1];
    end

    // Try the next root bit against the remainder
    always_comb begin
      tmp      = {rem_in, rad_in[W-1 -: 2]};
      trial    = (RW + 2)'({root_in, 2'b01});
      ge       = (tmp >= trial);
      rem_nxt  = ge ? RW'(tmp - trial) : RW'(tmp);
      root_nxt = {root_in[R-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= rad_in << 2;
        side_r[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[R-1];
  assign root_o = root_r[R-1];
  assign side_o = side_r[R-1];

endmodule
`default_nettype wire

[sv/ecct_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider, several numerators over one divisor
// One quotient bit per stage; the quotient must stay below 2^QW.
// ----------------------------------------------------------------------------
module ecct_div #(
  parameter int DW    = 32,
  parameter int QW    = 31,
  parameter int LANES = 3,
  parameter int SW    = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         vld_i,
  input  wire logic [LANES-1:0][DW+QW-1:0]  num_i,
  input  wire logic [DW-1:0]                den_i,
  input  wire logic [SW-1:0]                side_i,
  output logic                              vld_o,
  output logic [LANES-1:0][QW-1:0]          quot_o,
  output logic [SW-1:0]                     side_o
);

  localparam int XW = DW + QW;

  logic [XW-1:0] rem_r  [QW][LANES];
  logic [QW-1:0] quot_r [QW][LANES];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int B = QW - 1 - g;
    logic [XW-1:0] rem_in   [LANES];
    logic [QW-1:0] quot_in  [LANES];
    logic [XW-1:0] rem_nxt  [LANES];
    logic [QW-1:0] quot_nxt [LANES];
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [XW-1:0] shifted;

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l]  = num_i[l];
          quot_in[l] = '0;
        end
      end
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l]  = rem_r[g-1][l];
          quot_in[l] = quot_r[g-1][l];
        end
      end
      assign den_in  = den_r[g-1];
      assign side_in = side_r[g-1];
      assign vld_in  = vld_r[g-1];
    end

    // Subtract the shifted divisor where it fits
    always_comb begin
      shifted = XW'(den_in) << B;
      for (int l = 0; l < LANES; l++) begin
        quot_nxt[l] = quot_in[l];
        if (rem_in[l] >= shifted) begin
          rem_nxt[l]     = rem_in[l] - shifted;
          quot_nxt[l][B] = 1'b1;
        end else begin
          rem_nxt[l] = rem_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[g][l]  <= rem_nxt[l];
          quot_r[g][l] <= quot_nxt[l];
        end
        den_r[g]  <= den_in;
        side_r[g] <= side_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot_o[l] = quot_r[QW-1][l];
    end
  end

  assign vld_o  = vld_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule
`default_nettype wire

[sv/ecct_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end: classification and tangent geometry pipeline
// Accepts one item a cycle unless a full queue holds it, drops coincident
// centres, and finds the unit direction, internal angle and all point offsets.
// ----------------------------------------------------------------------------
module ecct_front #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire ecct_pkg::in_item_t in_data,
  input  wire logic              q_full_i,
  output logic                   rec_push_o,
  output ecct_pkg::rec_t         rec_o
);

  // Squared distance at or below this counts as coincident
  localparam logic [63:0] CoincLimit =
    ((64'd1 << (2 * FRACTION_BITS)) - 64'd1) / 64'd1000000000000;

  typedef struct packed {
    ecct_pkg::item_t item;
    logic [31:0]     axn;
    logic [31:0]     ayn;
    logic            sx;
    logic            sy;
    logic            k;
  } sq1_side_t;

  typedef struct packed {
    ecct_pkg::item_t item;
    logic            sx;
    logic            sy;
  } dv_side_t;

  typedef struct packed {
    ecct_pkg::item_t    item;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic [30:0]        ca;
  } sq2_side_t;

  logic en;
  logic take;

  // Stage 1: centre difference
  logic               s1_vld_r;
  ecct_pkg::item_t    s1_item_r;
  logic signed [32:0] s1_dx_r, s1_dy_r;
  // Stage 2: squares and normalization
  logic               s2_vld_r;
  ecct_pkg::item_t    s2_item_r;
  logic [65:0]        s2_sqx_r, s2_sqy_r;
  logic [63:0]        s2_r4_r;
  logic [31:0]        s2_axn_r, s2_ayn_r;
  logic               s2_sx_r, s2_sy_r, s2_k_r;
  // Stage 3: classification, normalized squares
  logic               s3_vld_r;
  ecct_pkg::item_t    s3_item_r;
  logic [63:0]        s3_nsqx_r, s3_nsqy_r;
  logic [31:0]        s3_axn_r, s3_ayn_r;
  logic               s3_sx_r, s3_sy_r, s3_k_r;
  // Stage 4: normalized squared distance
  logic               s4_vld_r;
  logic [63:0]        s4_nsq_r;
  sq1_side_t          s4_side_r;

  // Last stage of the pipeline
  logic               m4_vld_r;
  ecct_pkg::item_t    m4_item_r;
  logic               keep_out;

  logic [32:0]        ax, ay;
  logic               big;
  logic signed [32:0] dxn, dyn;
  logic [31:0]        axn, ayn;
  logic [65:0]        dsq;

  // Hold the whole pipeline while a kept item waits on a full queue
  assign keep_out = m4_vld_r && m4_item_r.keep;
  assign en       = !(keep_out && q_full_i);
  assign in_full  = !en;
  assign take     = in_push && en;

  always_comb begin
    ax  = s1_dx_r[32] ? 33'(-s1_dx_r) : 33'(s1_dx_r);
    ay  = s1_dy_r[32] ? 33'(-s1_dy_r) : 33'(s1_dy_r);
    big = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
    dxn = big ? (s1_dx_r >>> 1) : s1_dx_r;
    dyn = big ? (s1_dy_r >>> 1) : s1_dy_r;
    axn = dxn[32] ? 32'(-dxn) : 32'(dxn);
    ayn = dyn[32] ? 32'(-dyn) : 32'(dyn);
    dsq = s2_sqx_r + s2_sqy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= take;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Advance the classification stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r.x1       <= in_data.first_center_x;
      s1_item_r.y1       <= in_data.first_center_y;
      s1_item_r.x2       <= in_data.second_center_x;
      s1_item_r.y2       <= in_data.second_center_y;
      s1_item_r.r        <= in_data.circle_radius;
      s1_item_r.internal <= 1'b0;
      s1_item_r.keep     <= 1'b0;
      s1_dx_r <= 33'(in_data.second_center_x) - 33'(in_data.first_center_x);
      s1_dy_r <= 33'(in_data.second_center_y) - 33'(in_data.first_center_y);

      s2_item_r <= s1_item_r;
      s2_sqx_r  <= 66'(ax) * 66'(ax);
      s2_sqy_r  <= 66'(ay) * 66'(ay);
      s2_r4_r   <= {62'(s1_item_r.r) * 62'(s1_item_r.r), 2'b00};
      s2_axn_r  <= axn;
      s2_ayn_r  <= ayn;
      s2_sx_r   <= dxn[32];
      s2_sy_r   <= dyn[32];
      s2_k_r    <= big;

      s3_item_r <= {s2_item_r.x1, s2_item_r.y1, s2_item_r.x2, s2_item_r.y2,
                    s2_item_r.r, (dsq > 66'(s2_r4_r)), (dsq > 66'(CoincLimit))};
      s3_nsqx_r <= 64'(s2_axn_r) * 64'(s2_axn_r);
      s3_nsqy_r <= 64'(s2_ayn_r) * 64'(s2_ayn_r);
      s3_axn_r  <= s2_axn_r;
      s3_ayn_r  <= s2_ayn_r;
      s3_sx_r   <= s2_sx_r;
      s3_sy_r   <= s2_sy_r;
      s3_k_r    <= s2_k_r;

      s4_nsq_r       <= s3_nsqx_r + s3_nsqy_r;
      s4_side_r.item <= s3_item_r;
      s4_side_r.axn  <= s3_axn_r;
      s4_side_r.ayn  <= s3_ayn_r;
      s4_side_r.sx   <= s3_sx_r;
      s4_side_r.sy   <= s3_sy_r;
      s4_side_r.k    <= s3_k_r;
    end
  end

  // Distance root
  logic        sq1_vld;
  logic [31:0] sq1_root;
  logic [$bits(sq1_side_t)-1:0] sq1_side_raw;
  sq1_side_t   sq1_side;

  ecct_isqrt #(.W(64), .SW($bits(sq1_side_t))) u_isqrt_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s4_vld_r),
    .rad_i  (s4_nsq_r),
    .side_i (s4_side_r),
    .vld_o  (sq1_vld),
    .root_o (sq1_root),
    .side_o (sq1_side_raw)
  );

  assign sq1_side = sq1_side_raw;

  // Unit vector and internal cosine, rounded quotients over the distance
  logic [31:0]          dn;
  logic [61:0]          two_r;
  logic [2:0][62:0]     dv_num;
  dv_side_t             dv_in;
  logic                 dv_vld;
  logic [2:0][30:0]     dv_quot;
  logic [$bits(dv_side_t)-1:0] dv_side_raw;
  dv_side_t             dv_out;

  always_comb begin
    dn        = (sq1_root == 32'd0) ? 32'd1 : sq1_root;
    two_r     = {sq1_side.item.r, 31'd0} >> sq1_side.k;
    dv_num[0] = 63'({sq1_side.axn, 30'd0}) + 63'(dn >> 1);
    dv_num[1] = 63'({sq1_side.ayn, 30'd0}) + 63'(dn >> 1);
    dv_num[2] = 63'(two_r) + 63'(dn >> 1);
    dv_in.item = sq1_side.item;
    dv_in.sx   = sq1_side.sx;
    dv_in.sy   = sq1_side.sy;
  end

  ecct_div #(.DW(32), .QW(31), .LANES(3), .SW($bits(dv_side_t))) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq1_vld),
    .num_i  (dv_num),
    .den_i  (dn),
    .side_i (dv_in),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .side_o (dv_side_raw)
  );

  assign dv_out = dv_side_raw;

  // Apply signs, clamp the cosine, then square it
  logic               c1_vld_r, c2_vld_r;
  sq2_side_t          c1_side_r, c2_side_r;
  logic [61:0]        c2_casq_r;
  logic signed [31:0] ux_w, uy_w;

  always_comb begin
    ux_w = dv_out.sx ? -$signed({1'b0, dv_quot[0]}) : $signed({1'b0, dv_quot[0]});
    uy_w = dv_out.sy ? -$signed({1'b0, dv_quot[1]}) : $signed({1'b0, dv_quot[1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
    end else if (en) begin
      c1_vld_r <= dv_vld;
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_side_r.item <= dv_out.item;
      c1_side_r.ux   <= ux_w;
      c1_side_r.uy   <= uy_w;
      c1_side_r.ca   <= (dv_quot[2] > ecct_pkg::UnitOne) ? ecct_pkg::UnitOne : dv_quot[2];
      c2_side_r      <= c1_side_r;
      c2_casq_r      <= 62'(c1_side_r.ca) * 62'(c1_side_r.ca);
    end
  end

  // Internal sine
  logic        sq2_vld;
  logic [30:0] sq2_root;
  logic [$bits(sq2_side_t)-1:0] sq2_side_raw;
  sq2_side_t   sq2_side;

  ecct_isqrt #(.W(62), .SW($bits(sq2_side_t))) u_isqrt_sine (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (c2_vld_r),
    .rad_i  (ecct_pkg::UnitOneSq - c2_casq_r),
    .side_i (c2_side_r),
    .vld_o  (sq2_vld),
    .root_o (sq2_root),
    .side_o (sq2_side_raw)
  );

  assign sq2_side = sq2_side_raw;

  // Rotation and scaling stages
  logic               m1_vld_r, m2_vld_r, m3_vld_r;
  ecct_pkg::item_t    m1_item_r, m2_item_r, m3_item_r;
  logic signed [63:0] m1_uxca_r, m1_uysa_r, m1_uyca_r, m1_uxsa_r, m1_ea_r, m1_eb_r;
  logic signed [33:0] m2_c0_r, m2_s0_r, m2_c1_r, m2_s1_r, m2_a_r, m2_b_r;
  logic signed [63:0] m3_pc0_r, m3_ps0_r, m3_pc1_r, m3_ps1_r;
  logic signed [33:0] m3_a_r, m3_b_r;
  ecct_pkg::rec_t     m4_rec_r;

  logic signed [31:0] cas, sas, rs1, rs2, rs3;
  logic signed [65:0] pc0_w, ps0_w, pc1_w, ps1_w;

  always_comb begin
    cas   = $signed({1'b0, sq2_side.ca});
    sas   = $signed({1'b0, sq2_root});
    rs1   = $signed({1'b0, sq2_side.item.r});
    rs2   = $signed({1'b0, m2_item_r.r});
    rs3   = $signed({1'b0, m3_item_r.r});
    pc0_w = rs2 * m2_c0_r;
    ps0_w = rs2 * m2_s0_r;
    pc1_w = rs2 * m2_c1_r;
    ps1_w = rs2 * m2_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sq2_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_item_r <= sq2_side.item;
      m1_uxca_r <= sq2_side.ux * cas;
      m1_uysa_r <= sq2_side.uy * sas;
      m1_uyca_r <= sq2_side.uy * cas;
      m1_uxsa_r <= sq2_side.ux * sas;
      m1_ea_r   <= rs1 * sq2_side.uy;
      m1_eb_r   <= rs1 * sq2_side.ux;

      m2_item_r <= m1_item_r;
      m2_c0_r   <= ecct_pkg::rnd30(m1_uxca_r + m1_uysa_r);
      m2_s0_r   <= ecct_pkg::rnd30(m1_uyca_r - m1_uxsa_r);
      m2_c1_r   <= ecct_pkg::rnd30(m1_uxca_r - m1_uysa_r);
      m2_s1_r   <= ecct_pkg::rnd30(m1_uyca_r + m1_uxsa_r);
      m2_a_r    <= ecct_pkg::rnd30(m1_ea_r);
      m2_b_r    <= ecct_pkg::rnd30(m1_eb_r);

      m3_item_r <= m2_item_r;
      m3_pc0_r  <= pc0_w[63:0];
      m3_ps0_r  <= ps0_w[63:0];
      m3_pc1_r  <= pc1_w[63:0];
      m3_ps1_r  <= ps1_w[63:0];
      m3_a_r    <= m2_a_r;
      m3_b_r    <= m2_b_r;

      m4_item_r         <= m3_item_r;
      m4_rec_r.x1       <= m3_item_r.x1;
      m4_rec_r.y1       <= m3_item_r.y1;
      m4_rec_r.x2       <= m3_item_r.x2;
      m4_rec_r.y2       <= m3_item_r.y2;
      m4_rec_r.internal <= m3_item_r.internal && (rs3 >= 32'sd0);
      m4_rec_r.ext_a    <= m3_a_r;
      m4_rec_r.ext_b    <= m3_b_r;
      m4_rec_r.oc0      <= ecct_pkg::rnd30(m3_pc0_r);
      m4_rec_r.os0      <= ecct_pkg::rnd30(m3_ps0_r);
      m4_rec_r.oc1      <= ecct_pkg::rnd30(m3_pc1_r);
      m4_rec_r.os1      <= ecct_pkg::rnd30(m3_ps1_r);
    end
  end

  // Hand kept items to the queue
  assign rec_push_o = keep_out && !q_full_i;
  assign rec_o      = m4_rec_r;

endmodule
`default_nettype wire

[sv/ecct_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record queue
// Short first-in first-out buffer between the math pipeline and the sequencer.
// ----------------------------------------------------------------------------
module ecct_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ecct_pkg::rec_t push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output ecct_pkg::rec_t      head
);

  ecct_pkg::rec_t                mem_r [ecct_pkg::QDepth];
  logic [ecct_pkg::QPtrW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ecct_pkg::QPtrW:0]      cnt_r;

  assign full  = (cnt_r == (ecct_pkg::QPtrW + 1)'(ecct_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[sv/ecct_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result sequencer
// Steps through the two or four tangents of the head record, forms and
// saturates the points, and holds each result in the output register.
// ----------------------------------------------------------------------------
module ecct_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ecct_pkg::rec_t head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output ecct_pkg::out_item_t out_data
);

  logic [1:0]          idx_r;
  logic                out_vld_r;
  ecct_pkg::out_item_t out_data_r;

  logic                load;
  logic                last;
  logic signed [34:0]  o1x, o1y, o2x, o2y;
  ecct_pkg::out_item_t res;

  assign load = !q_empty && (!out_vld_r || out_pop);
  assign last = head.internal ? (idx_r == ecct_pkg::StepInt1) : (idx_r == ecct_pkg::StepExt1);

  // Pick the offsets of the current tangent
  always_comb begin
    case (idx_r)
      ecct_pkg::StepExt0: begin
        o1x = 35'(head.ext_a);
        o1y = -35'(head.ext_b);
        o2x = 35'(head.ext_a);
        o2y = -35'(head.ext_b);
      end
      ecct_pkg::StepExt1: begin
        o1x = -35'(head.ext_a);
        o1y = 35'(head.ext_b);
        o2x = -35'(head.ext_a);
        o2y = 35'(head.ext_b);
      end
      ecct_pkg::StepInt0: begin
        o1x = 35'(head.oc0);
        o1y = 35'(head.os0);
        o2x = -35'(head.oc0);
        o2y = -35'(head.os0);
      end
      default: begin
        o1x = 35'(head.oc1);
        o1y = 35'(head.os1);
        o2x = -35'(head.oc1);
        o2y = -35'(head.os1);
      end
    endcase
    res.point_one_x  = ecct_pkg::sat32(36'(head.x1) + 36'(o1x));
    res.point_one_y  = ecct_pkg::sat32(36'(head.y1) + 36'(o1y));
    res.point_two_x  = ecct_pkg::sat32(36'(head.x2) + 36'(o2x));
    res.point_two_y  = ecct_pkg::sat32(36'(head.y2) + 36'(o2y));
    res.tangent_kind = idx_r[1];
    res.tangent_side = idx_r[0];
    res.last_of_run  = last;
  end

  // Step through the run, drop the record after its last tangent
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= ecct_pkg::StepExt0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        idx_r     <= last ? ecct_pkg::StepExt0 : idx_r + 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign q_pop     = load && last;
  assign out_empty = !out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sv/equal_circle_common_tangents_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Common tangents of two equal circles
// Top level: geometry pipeline, record queue and result sequencer.
// ----------------------------------------------------------------------------
// Push two centres and a shared radius in signed fixed point; pop one result
// per common tangent: the two external tangents (side 0, then side 1), then
// the two internal ones when the centres are more than two radii apart.
// Coincident centres give no result. The geometry pipeline, with two root
// extractors of 32 and 31 stages and a 31-stage divider, takes a new item
// every cycle unless a full queue holds it. Results leave the output register
// one per cycle while each is popped at once; an item gives two results with
// external tangents only and four with internal ones, so the sequencer sets
// the item rate. A four-entry queue decouples the pipeline from the sequencer,
// and the whole pipeline holds while its last stage waits on a full queue.
module equal_circle_common_tangents_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire ecct_pkg::in_item_t in_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output ecct_pkg::out_item_t     out_data
);

  logic           q_full, q_empty, q_push, q_pop;
  ecct_pkg::rec_t q_wdata, q_head;

  ecct_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .q_full_i   (q_full),
    .rec_push_o (q_push),
    .rec_o      (q_wdata)
  );

  ecct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  ecct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
